[rtl/clu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clu_pkg
// shared types and codes for the 8-bit cpu load unit
// ----------------------------------------------------------------------------
package clu_pkg;

   typedef enum logic [2:0] {
      OP_MOVE     = 3'd0,
      OP_LOAD     = 3'd1,
      OP_STORE    = 3'd2,
      OP_PAIR_IMM = 3'd3,
      OP_SP_HL    = 3'd4,
      OP_STORE_SP = 3'd5,
      OP_HL_SP_E  = 3'd6,
      OP_NOP      = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      REG_A   = 3'd0,
      REG_B   = 3'd1,
      REG_C   = 3'd2,
      REG_D   = 3'd3,
      REG_E   = 3'd4,
      REG_H   = 3'd5,
      REG_L   = 3'd6,
      REG_IMM = 3'd7
   } reg_sel_type;

   typedef enum logic [1:0] {
      PAIR_BC = 2'd0,
      PAIR_DE = 2'd1,
      PAIR_HL = 2'd2,
      PAIR_SP = 2'd3
   } pair_type;

   typedef enum logic [2:0] {
      MODE_BC       = 3'd0,
      MODE_DE       = 3'd1,
      MODE_HL       = 3'd2,
      MODE_HL_INC   = 3'd3,
      MODE_HL_DEC   = 3'd4,
      MODE_IMM16    = 3'd5,
      MODE_HIGH_C   = 3'd6,
      MODE_HIGH_IMM = 3'd7
   } addr_mode_type;

   typedef enum logic [1:0] {
      BUS_NONE       = 2'd0,
      BUS_READ_BYTE  = 2'd1,
      BUS_WRITE_BYTE = 2'd2,
      BUS_WRITE_WORD = 2'd3
   } bus_kind_type;

   localparam int NUM_REGS = 7;
   localparam logic [7:0] HIGH_PAGE = 8'hFF;

   typedef logic [NUM_REGS-1:0][7:0] reg_file_type;

   typedef struct packed {
      op_type        op;
      reg_sel_type   dst_reg;
      reg_sel_type   src_reg;
      pair_type      reg_pair;
      addr_mode_type addr_mode;
      logic [15:0]   immediate;
      logic [7:0]    read_data;
   } item_type;

   typedef struct packed {
      bus_kind_type bus_kind;
      logic [15:0]  bus_address;
      logic [15:0]  bus_write_data;
      logic [15:0]  load_value;
      logic [3:0]   flags_value;
      logic [15:0]  hl_value;
      logic [15:0]  sp_value;
   } result_type;

endpackage
`default_nettype wire

[rtl/clu_exec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// clu_exec
// executes one load/move instruction against the register file, no storage
// ----------------------------------------------------------------------------
module clu_exec (
   input  clu_pkg::item_type     item,
   input  clu_pkg::reg_file_type cur_regs,
   input  logic [15:0]           cur_sp,
   input  logic [3:0]            cur_flags,
   output clu_pkg::reg_file_type next_regs,
   output logic [15:0]           next_sp,
   output logic [3:0]            next_flags,
   output clu_pkg::result_type   result
);
   import clu_pkg::*;

   logic [7:0]   src_byte;
   logic [15:0]  mode_addr;
   logic [15:0]  hl_cur;
   logic [15:0]  sp_ext_sum;
   logic [4:0]   half_sum;
   logic [8:0]   byte_sum;
   reg_file_type regs_w;
   result_type   res_w;
   logic         do_step;

   // source byte, code seven takes the low immediate byte
   always_comb begin
      if (item.src_reg == REG_IMM) begin
         src_byte = item.immediate[7:0];
      end else begin
         src_byte = cur_regs[item.src_reg];
      end
   end

   always_comb begin
      unique case (item.addr_mode)
         MODE_BC:       mode_addr = {cur_regs[REG_B], cur_regs[REG_C]};
         MODE_DE:       mode_addr = {cur_regs[REG_D], cur_regs[REG_E]};
         MODE_HL,
         MODE_HL_INC,
         MODE_HL_DEC:   mode_addr = {cur_regs[REG_H], cur_regs[REG_L]};
         MODE_IMM16:    mode_addr = item.immediate;
         MODE_HIGH_C:   mode_addr = {HIGH_PAGE, cur_regs[REG_C]};
         MODE_HIGH_IMM: mode_addr = {HIGH_PAGE, item.immediate[7:0]};
      endcase
   end

   // sp plus signed byte, half and full carry from the low byte
   assign sp_ext_sum = cur_sp + {{8{item.immediate[7]}}, item.immediate[7:0]};
   assign half_sum   = {1'b0, cur_sp[3:0]} + {1'b0, item.immediate[3:0]};
   assign byte_sum   = {1'b0, cur_sp[7:0]} + {1'b0, item.immediate[7:0]};

   always_comb begin
      regs_w               = cur_regs;
      next_sp              = cur_sp;
      next_flags           = cur_flags;
      res_w                = '0;
      res_w.bus_kind       = BUS_NONE;
      do_step              = 1'b0;

      unique case (item.op)
         OP_MOVE: begin
            if (item.dst_reg != REG_IMM) begin
               regs_w[item.dst_reg] = src_byte;
            end
            res_w.load_value = {8'h00, src_byte};
         end
         OP_LOAD: begin
            res_w.bus_kind    = BUS_READ_BYTE;
            res_w.bus_address = mode_addr;
            if (item.dst_reg != REG_IMM) begin
               regs_w[item.dst_reg] = item.read_data;
            end
            res_w.load_value = {8'h00, item.read_data};
            do_step          = 1'b1;
         end
         OP_STORE: begin
            res_w.bus_kind       = BUS_WRITE_BYTE;
            res_w.bus_address    = mode_addr;
            res_w.bus_write_data = {8'h00, src_byte};
            do_step              = 1'b1;
         end
         OP_PAIR_IMM: begin
            unique case (item.reg_pair)
               PAIR_BC: {regs_w[REG_B], regs_w[REG_C]} = item.immediate;
               PAIR_DE: {regs_w[REG_D], regs_w[REG_E]} = item.immediate;
               PAIR_HL: {regs_w[REG_H], regs_w[REG_L]} = item.immediate;
               PAIR_SP: next_sp = item.immediate;
            endcase
            res_w.load_value = item.immediate;
         end
         OP_SP_HL: begin
            next_sp          = {cur_regs[REG_H], cur_regs[REG_L]};
            res_w.load_value = {cur_regs[REG_H], cur_regs[REG_L]};
         end
         OP_STORE_SP: begin
            res_w.bus_kind       = BUS_WRITE_WORD;
            res_w.bus_address    = item.immediate;
            res_w.bus_write_data = cur_sp;
         end
         OP_HL_SP_E: begin
            {regs_w[REG_H], regs_w[REG_L]} = sp_ext_sum;
            next_flags       = {2'b00, half_sum[4], byte_sum[8]};
            res_w.load_value = sp_ext_sum;
         end
         OP_NOP: begin
         end
      endcase
   end

   // hl post step sees the register write of the same instruction
   always_comb begin
      next_regs = regs_w;
      hl_cur    = {regs_w[REG_H], regs_w[REG_L]};
      if (do_step && item.addr_mode == MODE_HL_INC) begin
         {next_regs[REG_H], next_regs[REG_L]} = hl_cur + 16'h0001;
      end else if (do_step && item.addr_mode == MODE_HL_DEC) begin
         {next_regs[REG_H], next_regs[REG_L]} = hl_cur - 16'h0001;
      end
      result             = res_w;
      result.flags_value = next_flags;
      result.hl_value    = {next_regs[REG_H], next_regs[REG_L]};
      result.sp_value    = next_sp;
   end

endmodule
`default_nettype wire

[rtl/cpu_load_unit_8bit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_load_unit_8bit
// load/move group of an 8-bit cpu, executed against its own register file
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     instruction beat (req_tdata, 40 bits)
//  rsp      out  rsp_tvalid/tready     result beat (rsp_tdata, 88 bits)
//
//  one beat per cycle sustained while rsp is ready; a request beat that is
//  taken is held in the input register, then the execute logic feeds the
//  result register once that register is free or being drained
//  the register file is written as a beat leaves the input register, so the
//  next beat always sees the state left by the one before it
//  reset clears the register file, sp, flags and both valid flags
//  a stalled rsp holds its beat; the input register keeps taking a beat
//  while the result register is free or being drained
//
module cpu_load_unit_8bit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[2:0] dst_reg[5:3] src_reg[8:6] reg_pair[10:9] addr_mode[13:11]
   // immediate[29:14] read_data[37:30] zero[39:38]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bus_kind[1:0] bus_address[17:2] bus_write_data[33:18] load_value[49:34]
   // flags_value[53:50] hl_value[69:54] sp_value[85:70] zero[87:86]
   output logic [87:0] rsp_tdata
);
   import clu_pkg::*;

   // input register
   item_type     item_ff;
   item_type     item_in;
   logic         item_valid_ff;
   logic         item_move;

   // architectural state
   reg_file_type regs_ff;
   reg_file_type regs_in;
   logic [15:0]  sp_ff;
   logic [15:0]  sp_in;
   logic [3:0]   flags_ff;
   logic [3:0]   flags_in;

   // result register
   result_type   result_ff;
   result_type   result_in;
   logic         rsp_valid_ff;

   // unpack the request beat
   assign item_in.op        = op_type'(req_tdata[2:0]);
   assign item_in.dst_reg   = reg_sel_type'(req_tdata[5:3]);
   assign item_in.src_reg   = reg_sel_type'(req_tdata[8:6]);
   assign item_in.reg_pair  = pair_type'(req_tdata[10:9]);
   assign item_in.addr_mode = addr_mode_type'(req_tdata[13:11]);
   assign item_in.immediate = req_tdata[29:14];
   assign item_in.read_data = req_tdata[37:30];

   // the held beat executes once the result register can take it
   assign item_move  = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || item_move;

   clu_exec u_exec (
      .item       (item_ff),
      .cur_regs   (regs_ff),
      .cur_sp     (sp_ff),
      .cur_flags  (flags_ff),
      .next_regs  (regs_in),
      .next_sp    (sp_in),
      .next_flags (flags_in),
      .result     (result_in)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   // state update and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= '0;
         sp_ff        <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (item_move) begin
         regs_ff      <= regs_in;
         sp_ff        <= sp_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (item_move) begin
         result_ff <= result_in;
      end
   end

   // pack the result beat
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata[1:0]   = result_ff.bus_kind;
   assign rsp_tdata[17:2]  = result_ff.bus_address;
   assign rsp_tdata[33:18] = result_ff.bus_write_data;
   assign rsp_tdata[49:34] = result_ff.load_value;
   assign rsp_tdata[53:50] = result_ff.flags_value;
   assign rsp_tdata[69:54] = result_ff.hl_value;
   assign rsp_tdata[85:70] = result_ff.sp_value;
   assign rsp_tdata[87:86] = 2'b00;

endmodule
`default_nettype wire
